// ===== src/csf_pkg.sv =====
// Package for the cylindrical swirl force block.
// Holds widths, register codes and the shared payload types; no dependencies.
package csf_pkg;

  // Default inner band bound on squared radial distance, Q16.16.
  localparam int MIN_DIST_SQ_DEF = 3277;

  // Datapath widths.
  localparam int XW  = 33;   // point minus origin
  localparam int PW  = 49;   // x times axis
  localparam int DTW = 37;   // dot product after the shift
  localparam int DPW = 53;   // dot times axis
  localparam int VW  = 39;   // radial vector
  localparam int VBW = 25;   // radial vector width that holds every in-band value
  localparam int MW  = 31;   // radial magnitude fed to the squarer
  localparam int SW  = 47;   // squared length carried to the back end
  localparam int CW  = 41;   // cross product component
  localparam int RW  = 24;   // square root width
  localparam int SQW = 50;   // square root remainder width
  localparam int QW  = 20;   // quotient magnitude bits
  localparam int DW  = 44;   // divider remainder width
  localparam int GW  = 32;   // gain and force width

  // Queue between front and back end.
  localparam int QDEPTH = 16;
  localparam int QAW    = $clog2(QDEPTH);

  // Number of register stages in the front end.
  localparam int NFRONT = 7;

  // Register index codes.
  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_AXIS_X     = 3'd3,
    REG_AXIS_Y     = 3'd4,
    REG_AXIS_Z     = 3'd5,
    REG_BAND_LIMIT = 3'd6,
    REG_GAIN       = 3'd7
  } csf_reg_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic        [30:0] band_limit;
    logic signed [31:0] gain;
  } csf_cfg_t;

  // One classified item as it travels from front to back end.
  typedef struct packed {
    logic        [SW-1:0] s;
    logic signed [CW-1:0] c0;
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] c2;
    logic                 inb;
  } csf_item_t;

endpackage

// ===== src/csf_front.sv =====
// Front end: accepts query points, projects out the axis and classifies the band.
// Depends on csf_pkg.
module csf_front #(
  parameter int MIN_DIST_SQ = csf_pkg::MIN_DIST_SQ_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [31:0]       in_pos_x,
  input  logic signed [31:0]       in_pos_y,
  input  logic signed [31:0]       in_pos_z,
  input  csf_pkg::csf_cfg_t        cfg,
  input  logic [csf_pkg::QAW:0]    q_count,
  output logic                     push,
  output csf_pkg::csf_item_t       push_item
);

  localparam int XW  = csf_pkg::XW;
  localparam int PW  = csf_pkg::PW;
  localparam int DTW = csf_pkg::DTW;
  localparam int DPW = csf_pkg::DPW;
  localparam int VW  = csf_pkg::VW;
  localparam int VBW = csf_pkg::VBW;
  localparam int MW  = csf_pkg::MW;
  localparam int CW  = csf_pkg::CW;
  localparam int SW  = csf_pkg::SW;
  localparam int NF  = csf_pkg::NFRONT;

  logic [NF-1:0] vld_r;
  logic          accept;

  logic signed [XW-1:0]  x1_r [0:2];
  logic signed [XW-1:0]  x2_r [0:2];
  logic signed [XW-1:0]  x3_r [0:2];
  logic signed [XW-1:0]  x4_r [0:2];
  logic signed [PW-1:0]  p_r  [0:2];
  logic signed [DTW-1:0] dot_r;
  logic signed [DPW-1:0] dp_r [0:2];
  logic signed [VW-1:0]  v_r  [0:2];
  logic [2*MW-1:0]       sq_r [0:2];
  logic                  ok_r;
  logic signed [CW-1:0]  cp_r [0:5];

  logic signed [PW+1:0]  psum;
  logic [VW-1:0]         vmag [0:2];
  logic                  vok  [0:2];
  logic signed [VBW-1:0] vb   [0:2];
  logic [63:0]           ssum;
  logic [31:0]           dist_sq;
  logic [$clog2(NF+1)-1:0] inflight;

  // Count items in the front stages and hold off when the queue could overflow.
  always_comb begin
    inflight = '0;
    for (int i = 0; i < NF; i++) begin
      inflight = inflight + ($clog2(NF+1))'(vld_r[i]);
    end
    busy = ((csf_pkg::QAW+2)'(q_count) + (csf_pkg::QAW+2)'(inflight))
           >= (csf_pkg::QAW+2)'(csf_pkg::QDEPTH);
  end

  assign accept = start && !busy;

  // Valid bits for each front stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NF-2:0], accept};
    end
  end

  // Combinational helpers for the later stages.
  always_comb begin
    psum = (PW+2)'(p_r[0]) + (PW+2)'(p_r[1]) + (PW+2)'(p_r[2]);
    for (int i = 0; i < 3; i++) begin
      vmag[i] = v_r[i][VW-1] ? VW'(-v_r[i]) : VW'(v_r[i]);
      vok[i]  = v_r[i][VW-1] ? ((&v_r[i][VW-1:MW]) && (|v_r[i][MW-1:0]))
                             : (v_r[i][VW-1:MW] == '0);
      vb[i]   = v_r[i][VBW-1:0];
    end
    ssum = 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
    dist_sq = (!ok_r || (|ssum[63:48])) ? 32'hFFFF_FFFF : ssum[47:16];
  end

  // Datapath stages; payload registers carry no reset.
  always_ff @(posedge clk) begin
    // Stage 1: point relative to the origin.
    x1_r[0] <= XW'(in_pos_x) - XW'(cfg.origin_x);
    x1_r[1] <= XW'(in_pos_y) - XW'(cfg.origin_y);
    x1_r[2] <= XW'(in_pos_z) - XW'(cfg.origin_z);
    // Stage 2: products with the axis.
    p_r[0] <= PW'(x1_r[0]) * PW'(cfg.axis_x);
    p_r[1] <= PW'(x1_r[1]) * PW'(cfg.axis_y);
    p_r[2] <= PW'(x1_r[2]) * PW'(cfg.axis_z);
    x2_r   <= x1_r;
    // Stage 3: dot product, floored to Q16.16.
    dot_r  <= DTW'(psum >>> 14);
    x3_r   <= x2_r;
    // Stage 4: axial component per coordinate.
    dp_r[0] <= DPW'(dot_r) * DPW'(cfg.axis_x);
    dp_r[1] <= DPW'(dot_r) * DPW'(cfg.axis_y);
    dp_r[2] <= DPW'(dot_r) * DPW'(cfg.axis_z);
    x4_r    <= x3_r;
    // Stage 5: radial vector.
    for (int i = 0; i < 3; i++) begin
      v_r[i] <= VW'(x4_r[i]) - VW'(dp_r[i] >>> 14);
    end
    // Stage 6: squares and cross product terms.
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= (2*MW)'(vmag[i][MW-1:0]) * (2*MW)'(vmag[i][MW-1:0]);
    end
    ok_r     <= vok[0] && vok[1] && vok[2];
    cp_r[0]  <= CW'(vb[1]) * CW'(cfg.axis_z);
    cp_r[1]  <= CW'(vb[2]) * CW'(cfg.axis_y);
    cp_r[2]  <= CW'(vb[2]) * CW'(cfg.axis_x);
    cp_r[3]  <= CW'(vb[0]) * CW'(cfg.axis_z);
    cp_r[4]  <= CW'(vb[0]) * CW'(cfg.axis_y);
    cp_r[5]  <= CW'(vb[1]) * CW'(cfg.axis_x);
    // Stage 7: squared length, band test and cross product.
    push_item.s   <= ssum[SW-1:0];
    push_item.c0  <= cp_r[0] - cp_r[1];
    push_item.c1  <= cp_r[2] - cp_r[3];
    push_item.c2  <= cp_r[4] - cp_r[5];
    push_item.inb <= (dist_sq >= 32'(MIN_DIST_SQ)) && (dist_sq <= {1'b0, cfg.band_limit});
  end

  assign push = vld_r[NF-1];

endmodule

// ===== src/csf_queue.sv =====
// Short queue that decouples the front end from the back end.
// Depends on csf_pkg.
module csf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  csf_pkg::csf_item_t    push_item,
  output logic [csf_pkg::QAW:0] count,
  output logic                  pop_vld,
  output csf_pkg::csf_item_t    pop_item
);

  localparam int QAW = csf_pkg::QAW;

  csf_pkg::csf_item_t mem [0:csf_pkg::QDEPTH-1];

  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           pop_vld_r;
  logic           pop;

  // The back end never stalls, so any stored beat leaves at once.
  assign pop = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      count_r   <= '0;
      pop_vld_r <= 1'b0;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      count_r   <= count_nxt;
      pop_vld_r <= pop;
    end
  end

  // Storage with a registered read port.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
    if (pop) begin
      pop_item <= mem[rd_ptr_r];
    end
  end

  assign count   = count_r;
  assign pop_vld = pop_vld_r;

endmodule

// ===== src/csf_back.sv =====
// Back end: square root, three dividers and the gain scaling, one beat per cycle.
// Depends on csf_pkg.
module csf_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  csf_pkg::csf_item_t       in_item,
  input  logic signed [31:0]       gain,
  output logic                     out_valid,
  output logic signed [31:0]       out_force_x,
  output logic signed [31:0]       out_force_y,
  output logic signed [31:0]       out_force_z,
  output logic                     out_in_band
);

  localparam int RW  = csf_pkg::RW;
  localparam int SQW = csf_pkg::SQW;
  localparam int QW  = csf_pkg::QW;
  localparam int DW  = csf_pkg::DW;
  localparam int CW  = csf_pkg::CW;
  localparam int GW  = csf_pkg::GW;
  localparam int QSW = QW + 2;
  localparam int PRW = GW + QSW;
  localparam int FW  = PRW - 16;
  localparam int NDLY = RW + 1 + QW + 2;

  // Valid pipeline for the whole back end.
  logic [NDLY-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NDLY-2:0], in_vld};
    end
  end

  // Square root, one result bit per stage.
  logic [SQW-1:0]       rt_rem_r  [0:RW];
  logic [RW-1:0]        rt_root_r [0:RW];
  logic signed [CW-1:0] rt_c_r    [0:RW][0:2];
  logic                 rt_inb_r  [0:RW];

  always_comb begin
    rt_rem_r[0]  = SQW'(in_item.s);
    rt_root_r[0] = '0;
    rt_c_r[0][0] = in_item.c0;
    rt_c_r[0][1] = in_item.c1;
    rt_c_r[0][2] = in_item.c2;
    rt_inb_r[0]  = in_item.inb;
  end

  for (genvar j = 1; j <= RW; j++) begin : g_root
    localparam int K = RW - j;
    logic [SQW-1:0] trial;
    assign trial = (SQW'(rt_root_r[j-1]) << (K + 1)) + (SQW'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if (rt_rem_r[j-1] >= trial) begin
        rt_rem_r[j]  <= rt_rem_r[j-1] - trial;
        rt_root_r[j] <= rt_root_r[j-1] | (RW'(1) << K);
      end else begin
        rt_rem_r[j]  <= rt_rem_r[j-1];
        rt_root_r[j] <= rt_root_r[j-1];
      end
      rt_c_r[j] <= rt_c_r[j-1];
      rt_inb_r[j] <= rt_inb_r[j-1];
    end
  end

  // Divider entry: magnitudes of four times the cross product.
  logic [DW-1:0]  dv_rem_r  [0:QW][0:2];
  logic [QW-1:0]  dv_q_r    [0:QW][0:2];
  logic [2:0]     dv_neg_r  [0:QW];
  logic [RW-1:0]  dv_r_r    [0:QW];
  logic           dv_inb_r  [0:QW];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= rt_c_r[RW][i][CW-1] ? DW'(-(DW'(rt_c_r[RW][i]) <<< 2))
                                            : DW'(DW'(rt_c_r[RW][i]) <<< 2);
      dv_q_r[0][i]   <= '0;
      dv_neg_r[0][i] <= rt_c_r[RW][i][CW-1];
    end
    dv_r_r[0]   <= rt_root_r[RW];
    dv_inb_r[0] <= rt_inb_r[RW];
  end

  // Restoring division, one quotient bit per stage, three lanes sharing the root.
  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int B = QW - j;
    logic [DW-1:0] den;
    assign den = DW'(dv_r_r[j-1]) << B;
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[j-1][i] >= den) begin
          dv_rem_r[j][i] <= dv_rem_r[j-1][i] - den;
          dv_q_r[j][i]   <= dv_q_r[j-1][i] | (QW'(1) << B);
        end else begin
          dv_rem_r[j][i] <= dv_rem_r[j-1][i];
          dv_q_r[j][i]   <= dv_q_r[j-1][i];
        end
      end
      dv_neg_r[j] <= dv_neg_r[j-1];
      dv_r_r[j]   <= dv_r_r[j-1];
      dv_inb_r[j] <= dv_inb_r[j-1];
    end
  end

  // Gain scaling of the signed quotients.
  logic signed [QSW-1:0] qs [0:2];
  logic signed [PRW-1:0] prod_r [0:2];
  logic                  prod_inb_r;
  logic signed [FW-1:0]  fsh [0:2];
  logic signed [GW-1:0]  fsat [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = dv_neg_r[QW][i] ? -QSW'(dv_q_r[QW][i]) : QSW'(dv_q_r[QW][i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= PRW'(gain) * PRW'(qs[i]);
    end
    prod_inb_r <= dv_inb_r[QW];
  end

  // Floor to Q16.16 and saturate to the signed 32-bit range.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fsh[i] = FW'(prod_r[i] >>> 16);
      if (fsh[i] > FW'(32'sh7FFF_FFFF)) begin
        fsat[i] = 32'sh7FFF_FFFF;
      end else if (fsh[i] < -FW'(33'sd2147483648)) begin
        fsat[i] = -32'sh7FFF_FFFF - 32'sd1;
      end else begin
        fsat[i] = fsh[i][GW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_force_x <= prod_inb_r ? fsat[0] : '0;
    out_force_y <= prod_inb_r ? fsat[1] : '0;
    out_force_z <= prod_inb_r ? fsat[2] : '0;
    out_in_band <= prod_inb_r;
  end

  assign out_valid = vld_r[NDLY-1];

endmodule

// ===== src/cylindrical_swirl_force_top.sv =====
// Top level of the cylindrical swirl force block: register file and APB port.
// Depends on csf_pkg, csf_front, csf_queue and csf_back.
//
// Usage: write the origin, unit axis (Q2.14), band limit and gain through the APB
// port while the block is idle; registers sit at byte addresses 4*i. A query point
// is taken on in_pos_x/y/z at each rising edge where start is high and busy is low.
// The result (out_force_x/y/z and out_in_band) is driven for exactly one cycle with
// out_valid high, once the accepted point has passed the front stages, the queue and
// the back end; results come out in the order of acceptance.
// A new point may be taken every cycle; the sustained rate is one point per cycle.
// The latency is set by the 24-stage square root and the 20-stage dividers in the
// back end, plus seven front stages and the queue's write and registered read.
// The receiver cannot hold results off, so the back end never stalls; busy only
// rises if the queue and front stages together could overfill, which does not
// happen with an always-draining back end.
// Synchronous reset (rst_n low) clears all in-flight beats and restores the
// register reset values: origin 0, axis (0, 0, 1.0), band limit 1.0, gain 0.
module cylindrical_swirl_force_top #(
  parameter int MIN_DIST_SQ = csf_pkg::MIN_DIST_SQ_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  // Result channel
  output logic               out_valid,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y,
  output logic signed [31:0] out_force_z,
  output logic               out_in_band
);

  csf_pkg::csf_cfg_t  cfg_r;
  csf_pkg::csf_reg_t  cfg_sel;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign cfg_sel = csf_pkg::csf_reg_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x   <= '0;
      cfg_r.origin_y   <= '0;
      cfg_r.origin_z   <= '0;
      cfg_r.axis_x     <= '0;
      cfg_r.axis_y     <= '0;
      cfg_r.axis_z     <= 16'sd16384;
      cfg_r.band_limit <= 31'd65536;
      cfg_r.gain       <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        csf_pkg::REG_ORIGIN_X:   cfg_r.origin_x   <= pwdata;
        csf_pkg::REG_ORIGIN_Y:   cfg_r.origin_y   <= pwdata;
        csf_pkg::REG_ORIGIN_Z:   cfg_r.origin_z   <= pwdata;
        csf_pkg::REG_AXIS_X:     cfg_r.axis_x     <= pwdata[15:0];
        csf_pkg::REG_AXIS_Y:     cfg_r.axis_y     <= pwdata[15:0];
        csf_pkg::REG_AXIS_Z:     cfg_r.axis_z     <= pwdata[15:0];
        csf_pkg::REG_BAND_LIMIT: cfg_r.band_limit <= pwdata[30:0];
        csf_pkg::REG_GAIN:       cfg_r.gain       <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (cfg_sel)
      csf_pkg::REG_ORIGIN_X:   prdata = cfg_r.origin_x;
      csf_pkg::REG_ORIGIN_Y:   prdata = cfg_r.origin_y;
      csf_pkg::REG_ORIGIN_Z:   prdata = cfg_r.origin_z;
      csf_pkg::REG_AXIS_X:     prdata = 32'(cfg_r.axis_x);
      csf_pkg::REG_AXIS_Y:     prdata = 32'(cfg_r.axis_y);
      csf_pkg::REG_AXIS_Z:     prdata = 32'(cfg_r.axis_z);
      csf_pkg::REG_BAND_LIMIT: prdata = {1'b0, cfg_r.band_limit};
      csf_pkg::REG_GAIN:       prdata = cfg_r.gain;
      default:                 prdata = '0;
    endcase
  end

  logic                      push;
  csf_pkg::csf_item_t        push_item;
  logic [csf_pkg::QAW:0]     q_count;
  logic                      pop_vld;
  csf_pkg::csf_item_t        pop_item;

  csf_front #(
    .MIN_DIST_SQ (MIN_DIST_SQ)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .in_pos_z  (in_pos_z),
    .cfg       (cfg_r),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  csf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .count     (q_count),
    .pop_vld   (pop_vld),
    .pop_item  (pop_item)
  );

  csf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (pop_vld),
    .in_item     (pop_item),
    .gain        (cfg_r.gain),
    .out_valid   (out_valid),
    .out_force_x (out_force_x),
    .out_force_y (out_force_y),
    .out_force_z (out_force_z),
    .out_in_band (out_in_band)
  );

endmodule

// ===== sim/csf_force_checker.sv =====
// Checker for the cylindrical swirl force block: follows register writes,
// predicts each force result and compares it with what comes out.
// Depends on csf_pkg for the register codes.
module csf_force_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic               out_valid,
  input  logic signed [31:0] out_force_x,
  input  logic signed [31:0] out_force_y,
  input  logic signed [31:0] out_force_z,
  input  logic               out_in_band,
  output int                 errors,
  output int                 pending,
  output int                 band_hits,
  output int                 results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MIN_DIST = 3277;

  typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic               inb;
  } force_t;

  force_t expected_forces[$];

  // Shadow copy of the register file.
  longint org_x, org_y, org_z, ax_x, ax_y, ax_z, gain;
  longint unsigned band;

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'h4000_0000_0000_0000;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned absval(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Force on one query point under the current register settings.
  function automatic force_t swirl_force(longint px, longint py, longint pz);
    force_t f;
    longint x0, x1, x2, dot, v0, v1, v2, r, c0, c1, c2;
    longint unsigned m0, m1, m2, s, dist_sq;
    x0 = px - org_x;
    x1 = py - org_y;
    x2 = pz - org_z;
    dot = (x0 * ax_x + x1 * ax_y + x2 * ax_z) >>> 14;
    v0 = x0 - ((dot * ax_x) >>> 14);
    v1 = x1 - ((dot * ax_y) >>> 14);
    v2 = x2 - ((dot * ax_z) >>> 14);
    m0 = absval(v0);
    m1 = absval(v1);
    m2 = absval(v2);
    s = 0;
    dist_sq = 64'hFFFF_FFFF;
    // Any large component saturates the squared distance.
    if (m0 < 64'h8000_0000 && m1 < 64'h8000_0000 && m2 < 64'h8000_0000) begin
      s = m0 * m0 + m1 * m1 + m2 * m2;
      dist_sq = s >> 16;
      if (dist_sq > 64'hFFFF_FFFF) dist_sq = 64'hFFFF_FFFF;
    end
    f.inb = (dist_sq >= MIN_DIST) && (dist_sq <= band);
    f.fx = 0;
    f.fy = 0;
    f.fz = 0;
    if (f.inb) begin
      r = longint'(root_floor(s));
      c0 = v1 * ax_z - v2 * ax_y;
      c1 = v2 * ax_x - v0 * ax_z;
      c2 = v0 * ax_y - v1 * ax_x;
      if (r > 0) begin
        f.fx = clamp32((gain * ((c0 * 4) / r)) >>> 16);
        f.fy = clamp32((gain * ((c1 * 4) / r)) >>> 16);
        f.fz = clamp32((gain * ((c2 * 4) / r)) >>> 16);
      end
    end
    return f;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Register writes, accepted beats and results, all sampled at the rising edge.
  always @(posedge clk) begin
    force_t w;
    if (!rst_n) begin
      org_x = 0; org_y = 0; org_z = 0;
      ax_x = 0; ax_y = 0; ax_z = 16384;
      band = 65536;
      gain = 0;
    end else begin
      if (out_valid) begin
        results_seen++;
        if (expected_forces.size() == 0) begin
          report("unexpected result, in_band", out_in_band, 0);
        end else begin
          w = expected_forces.pop_front();
          if (out_in_band) band_hits++;
          if (out_force_x !== w.fx) report("force_x", out_force_x, w.fx);
          if (out_force_y !== w.fy) report("force_y", out_force_y, w.fy);
          if (out_force_z !== w.fz) report("force_z", out_force_z, w.fz);
          if (out_in_band !== w.inb) report("in_band", out_in_band, w.inb);
        end
      end
      if (start && !busy)
        expected_forces.push_back(swirl_force(in_pos_x, in_pos_y, in_pos_z));
      if (psel && penable && pwrite && pready) begin
        case (csf_pkg::csf_reg_t'(paddr[4:2]))
          csf_pkg::REG_ORIGIN_X:   org_x = longint'(signed'(pwdata));
          csf_pkg::REG_ORIGIN_Y:   org_y = longint'(signed'(pwdata));
          csf_pkg::REG_ORIGIN_Z:   org_z = longint'(signed'(pwdata));
          csf_pkg::REG_AXIS_X:     ax_x = longint'(signed'(pwdata[15:0]));
          csf_pkg::REG_AXIS_Y:     ax_y = longint'(signed'(pwdata[15:0]));
          csf_pkg::REG_AXIS_Z:     ax_z = longint'(signed'(pwdata[15:0]));
          csf_pkg::REG_BAND_LIMIT: band = pwdata[30:0];
          csf_pkg::REG_GAIN:       gain = longint'(signed'(pwdata));
          default: ;
        endcase
      end
    end
    pending = expected_forces.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    band_hits = 0;
    results_seen = 0;
  end

endmodule

// ===== sim/cylindrical_swirl_force_top_tb.sv =====
// Testbench top for the cylindrical swirl force block: drives register phases
// and query points, and gives the verdict from csf_force_checker's count.
// Depends on csf_pkg, cylindrical_swirl_force_top and csf_force_checker.
module cylindrical_swirl_force_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic start = 0;
  logic busy;
  logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
  logic out_valid, out_in_band;
  logic signed [31:0] force_x, force_y, force_z;
  int errors, pending, band_hits, results_seen;
  int cycles = 0;
  int points_sent = 0;
  logic signed [31:0] cur_org_x, cur_org_y, cur_org_z;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  cylindrical_swirl_force_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .in_pos_x(pos_x), .in_pos_y(pos_y), .in_pos_z(pos_z),
    .out_valid(out_valid), .out_force_x(force_x), .out_force_y(force_y),
    .out_force_z(force_z), .out_in_band(out_in_band)
  );

  csf_force_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .start(start), .busy(busy),
    .in_pos_x(pos_x), .in_pos_y(pos_y), .in_pos_z(pos_z),
    .out_valid(out_valid), .out_force_x(force_x), .out_force_y(force_y),
    .out_force_z(force_z), .out_in_band(out_in_band),
    .errors(errors), .pending(pending), .band_hits(band_hits),
    .results_seen(results_seen)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("cylindrical_swirl_force_top: mismatch");
      $finish;
    end
  end

  // One register write: setup cycle, then access cycle.
  task automatic reg_write(csf_pkg::csf_reg_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    if (idx == csf_pkg::REG_ORIGIN_X) cur_org_x = val;
    if (idx == csf_pkg::REG_ORIGIN_Y) cur_org_y = val;
    if (idx == csf_pkg::REG_ORIGIN_Z) cur_org_z = val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_regs(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [15:0] axx, logic [15:0] axy, logic [15:0] axz,
                          logic [31:0] lim, logic [31:0] g);
    reg_write(csf_pkg::REG_ORIGIN_X, ox);
    reg_write(csf_pkg::REG_ORIGIN_Y, oy);
    reg_write(csf_pkg::REG_ORIGIN_Z, oz);
    reg_write(csf_pkg::REG_AXIS_X, {{16{axx[15]}}, axx});
    reg_write(csf_pkg::REG_AXIS_Y, {{16{axy[15]}}, axy});
    reg_write(csf_pkg::REG_AXIS_Z, {{16{axz[15]}}, axz});
    reg_write(csf_pkg::REG_BAND_LIMIT, lim);
    reg_write(csf_pkg::REG_GAIN, g);
  endtask

  // One query beat after a random gap; held until the block takes it.
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            bit no_gap);
    int gap;
    logic was_busy;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    forever begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
    end
    points_sent++;
  endtask

  // Mostly points near the axis origin so that the band is reached; some noise.
  task automatic random_points(int count);
    int k, burst;
    logic [31:0] ox, oy, oz;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) burst = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : 0;
      if ($urandom_range(0, 9) < 2) begin
        ox = $urandom; oy = $urandom; oz = $urandom;
      end else begin
        k = $urandom_range(6, 25);
        ox = cur_org_x + (signed'($urandom) >>> (31 - k));
        oy = cur_org_y + (signed'($urandom) >>> (31 - k));
        oz = cur_org_z + (signed'($urandom) >>> (31 - k));
      end
      send_point(ox, oy, oz, burst > 0);
      if (burst > 0) burst--;
    end
  endtask

  // Sender holds off until every expected result is in.
  task automatic drain;
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    cur_org_x = 0; cur_org_y = 0; cur_org_z = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // Defaults first: zero gain, unit z axis.
    random_points(60);
    drain();

    // Directed points with a wide band and unit gain.
    set_regs(0, 0, 0, 0, 0, 16384, 32'h7FFF_FFFF, 32'h0001_0000);
    send_point(0, 0, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_point(32'h0001_0000, 0, 32'h1234_5678, 0);
    send_point(0, 32'hFFFF_0000, 0, 0);
    send_point(14655, 0, 0, 0);           // just at the inner bound
    send_point(14654, 0, 0, 0);           // just inside the excluded core
    send_point(0, -14655, 32'h8000_0000, 0);
    send_point(32'h00B5_0000, 0, 0, 0);   // near the outer bound
    send_point(32'h00B5_0500, 0, 0, 0);   // just past it
    send_point(32'h0080_0000, 32'h0080_0000, 0, 1);
    send_point(32'hFF80_0000, 32'h0040_0000, 5, 1);
    send_point(32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_0000, 1);
    drain();

    // Register phases: axes, band extremes, gain extremes, origins.
    set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h0012_3456, 16384, 0, 0,
             32'h7FFF_FFFF, 32'h7FFF_FFFF);
    random_points(180);
    drain();
    set_regs(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, -16384, 0, 0, 32'h8000_0000);
    random_points(100);
    drain();
    set_regs(32'h0100_0000, 32'hFF00_0000, 32'h0000_0001, 11585, 0, -11585,
             32'h0010_0000, 32'hFFFF_0000);
    random_points(200);
    drain();
    set_regs(0, 0, 0, -16384, 16384, -16384, 32'h0000_0CCD, 32'h7FFF_FFFF);
    random_points(150);
    drain();
    set_regs(32'hFFFF_FFFF, 0, 32'h8000_0000, 9459, 9459, 9459, 32'h7FFF_FFFF,
             32'h0032_0000);
    random_points(200);
    drain();
    set_regs(5, 6, 7, 0, 0, -16384, 32'hFFFF_FFFF, 32'h8000_0001);
    random_points(150);
    drain();
    for (int p = 0; p < 3; p++) begin
      set_regs($urandom, $urandom, $urandom, 16'($urandom_range(0, 32768) - 16384),
               16'($urandom_range(0, 32768) - 16384), 16'($urandom), $urandom,
               $urandom);
      random_points(160);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d query points over 11 register settings; %0d results, %0d in band",
             points_sent, results_seen, band_hits);
    if (errors == 0 && pending == 0) begin
      $display("cylindrical_swirl_force_top: match");
    end else begin
      $display("%0d errors, %0d results missing", errors, pending);
      $display("cylindrical_swirl_force_top: mismatch");
    end
    $finish;
  end
endmodule

// ===== cylindrical_swirl_force_top.f =====
src/csf_pkg.sv
src/csf_front.sv
src/csf_queue.sv
src/csf_back.sv
src/cylindrical_swirl_force_top.sv
sim/csf_force_checker.sv
sim/cylindrical_swirl_force_top_tb.sv
